>>> rtl/brpe_pkg.sv
// Shared types and constants for the binary relation property engine.
// Holds the command and response words, matrix types and action codes.
// No dependencies.
package brpe_pkg;

	localparam int ELEM_COUNT = 16;
	localparam int IDX_W      = $clog2(ELEM_COUNT);
	localparam int CNT_W      = $clog2(ELEM_COUNT * ELEM_COUNT) + 1;
	localparam int ADDR_W     = 3;
	localparam int DATA_W     = 32;

	localparam logic [2:0] ACT_ADD  = 3'd0;
	localparam logic [2:0] ACT_DEL  = 3'd1;
	localparam logic [2:0] ACT_TEST = 3'd2;
	localparam logic [2:0] ACT_SUCC = 3'd3;
	localparam logic [2:0] ACT_EVAL = 3'd4;

	localparam logic REG_ELEMENT_MASK = 1'b0;

	typedef logic [ELEM_COUNT-1:0]                 row_t;
	typedef logic [ELEM_COUNT-1:0][ELEM_COUNT-1:0] matrix_t;
	typedef logic [IDX_W-1:0]                      idx_t;
	typedef logic [CNT_W-1:0]                      cnt_t;

	typedef struct packed {
		logic [2:0] action;
		idx_t       first_element;
		idx_t       second_element;
	} brpe_cmd_t;

	typedef struct packed {
		logic inserted;
		logic is_present;
		cnt_t pair_count;
		logic reflexive_flag;
		logic irreflexive_flag;
		logic symmetric_flag;
		logic asymmetric_flag;
		logic transitive_flag;
		logic function_flag;
		row_t successor_mask;
	} brpe_rsp_t;

	// per-row property violations, accumulated over a sweep
	typedef struct packed {
		logic refl_miss;
		logic irrefl_hit;
		logic sym_miss;
		logic asym_hit;
		logic trans_miss;
		logic func_miss;
	} brpe_viol_t;

endpackage

>>> rtl/brpe_row_check.sv
// Row property checker: finds the property violations of one matrix row.
// Shared across all rows of a property sweep under the top-level sequencer.
// Depends on brpe_pkg.
module brpe_row_check (
	input  brpe_pkg::matrix_t    matrix,
	input  brpe_pkg::row_t       mask,
	input  brpe_pkg::idx_t       idx,
	output brpe_pkg::brpe_viol_t viol
);
	import brpe_pkg::*;

	row_t row;
	row_t col;
	row_t reach;
	row_t diag;

	always_comb begin
		row   = matrix[idx];
		col   = '0;
		reach = '0;
		for (int j = 0; j < ELEM_COUNT; j++) begin
			col[j] = matrix[j][idx];
			if (row[j]) begin
				reach = reach | matrix[j];
			end
		end
		diag = row_t'(1) << idx;

		viol.refl_miss  = mask[idx] & ~row[idx];
		viol.irrefl_hit = mask[idx] & row[idx];
		viol.sym_miss   = |(row & ~col);
		viol.asym_hit   = |(row & col & ~diag);
		viol.trans_miss = |(reach & mask & ~row);
		viol.func_miss  = |(row & (row - row_t'(1)));
	end

endmodule

>>> rtl/binary_relation_property_engine.sv
// Binary relation property engine, top level.
// Add, remove, test and successor words: response registered in the cycle after accept.
// Evaluate words: one row of the matrix per cycle through the shared row checker,
// 16 row steps, then a done step that posts the response once the response register is free.
// One word in flight at a time; a new word is taken while the response register drains.
// Reset clears the matrix, the pair count, the element mask and any pending response.
module binary_relation_property_engine (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [brpe_pkg::ADDR_W-1:0]    paddr,
	input  logic [brpe_pkg::DATA_W-1:0]    pwdata,
	output logic [brpe_pkg::DATA_W-1:0]    prdata,
	output logic                           pready,
	input  logic                           cmd_valid,
	output logic                           cmd_stall,
	input  brpe_pkg::brpe_cmd_t            cmd,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output brpe_pkg::brpe_rsp_t            rsp
);
	import brpe_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DONE
	} state_t;

	localparam idx_t LAST_ROW = idx_t'(ELEM_COUNT - 1);

	state_t     state_q;
	matrix_t    matrix_q;
	row_t       mask_q;
	cnt_t       count_q;
	idx_t       row_q;
	brpe_viol_t viol_q;
	brpe_rsp_t  rsp_q;
	logic       rsp_valid_q;

	brpe_viol_t row_viol;
	brpe_rsp_t  simple_rsp;
	brpe_rsp_t  eval_rsp;
	brpe_rsp_t  rsp_nxt;
	row_t       row_a;
	logic       hit;
	logic       add_ok;
	logic       do_set;
	logic       do_clr;
	logic       rsp_free;
	logic       rsp_load;
	logic       cmd_fire;
	logic       cfg_wr;
	cnt_t       count_nxt;

	assign pready    = 1'b1;
	assign prdata    = (paddr[2] == REG_ELEMENT_MASK) ? DATA_W'(mask_q) : '0;
	assign cfg_wr    = psel & penable & pwrite & pready & (paddr[2] == REG_ELEMENT_MASK);

	assign rsp_free  = ~rsp_valid_q | ~rsp_stall;
	assign cmd_stall = (state_q != ST_IDLE) | ~rsp_free;
	assign cmd_fire  = cmd_valid & ~cmd_stall;
	assign rsp_load  = (cmd_fire & (cmd.action != ACT_EVAL)) | ((state_q == ST_DONE) & rsp_free);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	brpe_row_check u_row_check (
		.matrix (matrix_q),
		.mask   (mask_q),
		.idx    (row_q),
		.viol   (row_viol)
	);

	always_comb begin
		row_a      = matrix_q[cmd.first_element];
		hit        = row_a[cmd.second_element];
		add_ok     = mask_q[cmd.first_element] & mask_q[cmd.second_element] & ~hit;
		do_set     = 1'b0;
		do_clr     = 1'b0;
		count_nxt  = count_q;
		simple_rsp = '0;
		case (cmd.action)
			ACT_ADD: begin
				do_set              = add_ok;
				simple_rsp.inserted = add_ok;
				if (add_ok) begin
					count_nxt = count_q + cnt_t'(1);
				end
			end
			ACT_DEL: begin
				do_clr = hit;
				if (hit) begin
					count_nxt = count_q - cnt_t'(1);
				end
			end
			ACT_TEST: begin
				simple_rsp.is_present = hit;
			end
			ACT_SUCC: begin
				simple_rsp.successor_mask = row_a;
			end
			default: begin
			end
		endcase
		simple_rsp.pair_count = count_nxt;

		eval_rsp                  = '0;
		eval_rsp.pair_count       = count_q;
		eval_rsp.reflexive_flag   = ~viol_q.refl_miss;
		eval_rsp.irreflexive_flag = ~viol_q.irrefl_hit;
		eval_rsp.symmetric_flag   = ~viol_q.sym_miss;
		eval_rsp.asymmetric_flag  = ~viol_q.asym_hit;
		eval_rsp.transitive_flag  = ~viol_q.trans_miss;
		eval_rsp.function_flag    = ~viol_q.func_miss;

		rsp_nxt = (state_q == ST_DONE) ? eval_rsp : simple_rsp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_q <= '0;
		end else if (cmd_fire) begin
			if (do_set) begin
				matrix_q[cmd.first_element][cmd.second_element] <= 1'b1;
			end else if (do_clr) begin
				matrix_q[cmd.first_element][cmd.second_element] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mask_q      <= '0;
			count_q     <= '0;
			row_q       <= '0;
			viol_q      <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				mask_q <= pwdata[ELEM_COUNT-1:0];
			end
			if (rsp_load) begin
				rsp_q       <= rsp_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						count_q <= count_nxt;
						if (cmd.action == ACT_EVAL) begin
							state_q <= ST_EVAL;
							row_q   <= '0;
							viol_q  <= '0;
						end
					end
				end
				ST_EVAL: begin
					viol_q <= viol_q | row_viol;
					row_q  <= row_q + idx_t'(1);
					if (row_q == LAST_ROW) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/brpe_checker.sv
// Port-level checker for the binary relation property engine, with its bind.
// Watches the command and response channels over time.
// Depends on brpe_pkg and binary_relation_property_engine.
module brpe_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                cmd_valid,
	input logic                cmd_stall,
	input brpe_pkg::brpe_cmd_t cmd,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input brpe_pkg::brpe_rsp_t rsp
);
	import brpe_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response word changed while stalled");

	a_simple_next: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall && cmd.action != ACT_EVAL |=> rsp_valid)
		else $error("simple word gave no response in the next cycle");

	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall && cmd.action == ACT_EVAL |=> cmd_stall && !rsp_valid)
		else $error("engine not busy after evaluate word");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.pair_count <= 9'd256)
		else $error("pair count out of range");

	a_flags_alone: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.reflexive_flag |->
			!rsp.inserted && !rsp.is_present && rsp.successor_mask == '0)
		else $error("property flags mixed with another answer");

endmodule

bind binary_relation_property_engine brpe_checker u_brpe_checker (.*);

>>> bench/tb.sv
// Self-checking bench for binary_relation_property_engine: APB mask writes, command words
// checked against a bit-matrix model of the relation kept here. Depends on brpe_pkg and the RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import brpe_pkg::*;

	localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
	localparam logic [2:0] ACT_SPARE_MID   = 3'd6;
	localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;
	localparam int         WATCHDOG_LIMIT  = 3000;
	localparam int         HOLD_OFF_CYCLES = 120;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              psel     = 1'b0;
	logic              penable  = 1'b0;
	logic              pwrite   = 1'b0;
	logic [ADDR_W-1:0] paddr    = '0;
	logic [DATA_W-1:0] pwdata   = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              cmd_valid = 1'b0;
	logic              cmd_stall;
	brpe_cmd_t         cmd       = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	brpe_rsp_t         rsp;

	// relation model
	row_t link_rows [ELEM_COUNT];
	cnt_t link_total = '0;
	row_t base_mask  = '0;

	brpe_cmd_t words_to_send [$];
	brpe_rsp_t answers_due [$];

	int sender_idle_pct = 38;
	int rsp_idle_pct    = 80;
	int words_taken     = 0;
	int taken_seen      = 0;
	int hold_off_asks   = 0;
	int hold_off_seen   = 0;
	int hold_left       = 0;
	int quiet_cycles    = 0;
	int failures        = 0;

	binary_relation_property_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic brpe_rsp_t relation_answer(input brpe_cmd_t w);
		brpe_rsp_t r;
		row_t      row;
		logic      refl, irrefl, sym, asym, trans, func;
		r = '0;
		case (w.action)
			ACT_ADD: begin
				if (base_mask[w.first_element] && base_mask[w.second_element]
						&& !link_rows[w.first_element][w.second_element]) begin
					link_rows[w.first_element][w.second_element] = 1'b1;
					link_total++;
					r.inserted = 1'b1;
				end
			end
			ACT_DEL: begin
				if (link_rows[w.first_element][w.second_element]) begin
					link_rows[w.first_element][w.second_element] = 1'b0;
					link_total--;
				end
			end
			ACT_TEST: r.is_present = link_rows[w.first_element][w.second_element];
			ACT_SUCC: r.successor_mask = link_rows[w.first_element];
			ACT_EVAL: begin
				refl = 1'b1; irrefl = 1'b1; sym = 1'b1;
				asym = 1'b1; trans = 1'b1; func = 1'b1;
				for (int i = 0; i < ELEM_COUNT; i++) begin
					row = link_rows[i];
					if (base_mask[i]) begin
						if (row[i]) irrefl = 1'b0;
						else refl = 1'b0;
					end
					if ((row & (row - row_t'(1))) != '0) func = 1'b0;
					for (int j = 0; j < ELEM_COUNT; j++) begin
						if (row[j]) begin
							if (!link_rows[j][i]) sym = 1'b0;
							else if (i != j) asym = 1'b0;
							if ((link_rows[j] & base_mask & ~row) != '0) trans = 1'b0;
						end
					end
				end
				r.reflexive_flag   = refl;
				r.irreflexive_flag = irrefl;
				r.symmetric_flag   = sym;
				r.asymmetric_flag  = asym;
				r.transitive_flag  = trans;
				r.function_flag    = func;
			end
			default: ;
		endcase
		r.pair_count = link_total;
		return r;
	endfunction

	function automatic brpe_cmd_t word(input logic [2:0] act, input int a, input int b);
		brpe_cmd_t w;
		w.action         = act;
		w.first_element  = idx_t'(a);
		w.second_element = idx_t'(b);
		return w;
	endfunction

	function automatic idx_t pick_elem();
		idx_t e;
		if (base_mask != '0 && $urandom_range(99) < 80) begin
			do e = idx_t'($urandom_range(ELEM_COUNT - 1)); while (!base_mask[e]);
		end else begin
			e = idx_t'($urandom_range(ELEM_COUNT - 1));
		end
		return e;
	endfunction

	function automatic row_t pick_mask();
		row_t m;
		m = '0;
		case ($urandom_range(3))
			0: m = '1;
			1: m = row_t'($urandom_range(16'hFFFF));
			default: repeat ($urandom_range(2, 4)) m[$urandom_range(ELEM_COUNT - 1)] = 1'b1;
		endcase
		return m;
	endfunction

	task automatic send_random(input int n);
		brpe_cmd_t w;
		int        roll;
		repeat (n) begin
			roll = $urandom_range(99);
			w.first_element  = pick_elem();
			w.second_element = pick_elem();
			if (roll < 35) w.action = ACT_ADD;
			else if (roll < 50) w.action = ACT_DEL;
			else if (roll < 65) w.action = ACT_TEST;
			else if (roll < 75) w.action = ACT_SUCC;
			else if (roll < 94) w.action = ACT_EVAL;
			else w.action = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
			words_to_send.push_back(w);
		end
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (words_to_send.size() != 0 || cmd_valid || answers_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_element_mask(input row_t value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({REG_ELEMENT_MASK, 2'b00});
		pwdata  <= DATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		base_mask = value;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== DATA_W'(value)) begin
			$display("%0t mismatch element_mask readback: expected %0h, got %0h",
				$time, value, prdata);
			failures++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// sender: take the next word once the current one is accepted
	always @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			answers_due.push_back(relation_answer(cmd));
			words_taken++;
		end
	end

	always @(negedge clk) begin
		if (!cmd_valid || taken_seen != words_taken) begin
			taken_seen = words_taken;
			if (words_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				cmd       <= words_to_send.pop_front();
				cmd_valid <= 1'b1;
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// receiver: random stall, or a long hold-off on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_off_seen != hold_off_asks) begin
			hold_off_seen = hold_off_asks;
			rsp_stall     <= 1'b1;
			hold_left     <= HOLD_OFF_CYCLES;
		end else begin
			rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
		end
	end

	task automatic report_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (want !== got) begin
			$display("%0t mismatch %s: expected %0h, got %0h", $time, name, want, got);
			failures++;
		end
	endtask

	always @(posedge clk) begin : monitor
		brpe_rsp_t want;
		if (rsp_valid && !rsp_stall) begin
			if (answers_due.size() == 0) begin
				$display("%0t mismatch unexpected word: expected none, got %0h", $time, rsp);
				failures++;
			end else begin
				want = answers_due.pop_front();
				report_field("inserted", 16'(want.inserted), 16'(rsp.inserted));
				report_field("is_present", 16'(want.is_present), 16'(rsp.is_present));
				report_field("pair_count", 16'(want.pair_count), 16'(rsp.pair_count));
				report_field("reflexive_flag", 16'(want.reflexive_flag),
					16'(rsp.reflexive_flag));
				report_field("irreflexive_flag", 16'(want.irreflexive_flag),
					16'(rsp.irreflexive_flag));
				report_field("symmetric_flag", 16'(want.symmetric_flag),
					16'(rsp.symmetric_flag));
				report_field("asymmetric_flag", 16'(want.asymmetric_flag),
					16'(rsp.asymmetric_flag));
				report_field("transitive_flag", 16'(want.transitive_flag),
					16'(rsp.transitive_flag));
				report_field("function_flag", 16'(want.function_flag),
					16'(rsp.function_flag));
				report_field("successor_mask", want.successor_mask, rsp.successor_mask);
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int order [ELEM_COUNT * ELEM_COUNT];
		int j, t;
		for (int i = 0; i < ELEM_COUNT; i++) link_rows[i] = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// empty base set after reset
		words_to_send.push_back(word(ACT_ADD, 0, 0));
		words_to_send.push_back(word(ACT_EVAL, 0, 0));
		words_to_send.push_back(word(ACT_SPARE_FIRST, 15, 15));
		wait_drained();

		write_element_mask('1);
		words_to_send.push_back(word(ACT_ADD, 0, 0));
		words_to_send.push_back(word(ACT_ADD, 15, 15));
		words_to_send.push_back(word(ACT_ADD, 0, 15));
		words_to_send.push_back(word(ACT_ADD, 0, 15));
		words_to_send.push_back(word(ACT_TEST, 0, 15));
		words_to_send.push_back(word(ACT_TEST, 15, 0));
		words_to_send.push_back(word(ACT_SUCC, 0, 0));
		words_to_send.push_back(word(ACT_SUCC, 15, 0));
		words_to_send.push_back(word(ACT_EVAL, 0, 0));
		words_to_send.push_back(word(ACT_DEL, 0, 15));
		words_to_send.push_back(word(ACT_DEL, 0, 15));
		words_to_send.push_back(word(ACT_ADD, 15, 0));
		words_to_send.push_back(word(ACT_ADD, 0, 15));
		words_to_send.push_back(word(ACT_EVAL, 15, 15));
		words_to_send.push_back(word(ACT_SPARE_MID, 5, 10));
		words_to_send.push_back(word(ACT_SPARE_LAST, 10, 5));
		words_to_send.push_back(word(ACT_TEST, 15, 15));
		wait_drained();

		// shrink the base set while pairs are held
		write_element_mask(16'h0006);
		words_to_send.push_back(word(ACT_ADD, 1, 2));
		words_to_send.push_back(word(ACT_ADD, 3, 1));
		words_to_send.push_back(word(ACT_EVAL, 0, 0));
		words_to_send.push_back(word(ACT_TEST, 0, 15));
		words_to_send.push_back(word(ACT_DEL, 0, 0));
		words_to_send.push_back(word(ACT_SUCC, 15, 0));
		wait_drained();

		hold_off_asks++;
		repeat (4) begin
			write_element_mask(pick_mask());
			send_random(50);
			wait_drained();
		end

		sender_idle_pct = 80;
		rsp_idle_pct    = 38;
		write_element_mask('1);
		for (int i = 0; i < ELEM_COUNT * ELEM_COUNT; i++) order[i] = i;
		for (int i = ELEM_COUNT * ELEM_COUNT - 1; i > 0; i--) begin
			j = $urandom_range(i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		for (int i = 0; i < ELEM_COUNT * ELEM_COUNT; i++)
			words_to_send.push_back(word(ACT_ADD, order[i] / ELEM_COUNT, order[i] % ELEM_COUNT));
		words_to_send.push_back(word(ACT_EVAL, 0, 0));
		send_random(60);
		wait_drained();

		sender_idle_pct = 0;
		rsp_idle_pct    = 0;
		write_element_mask('0);
		send_random(50);
		wait_drained();
		write_element_mask('1);
		send_random(50);
		wait_drained();
		repeat (2) begin
			write_element_mask(pick_mask());
			send_random(50);
			wait_drained();
		end

		repeat (40) @(posedge clk);
		if (failures == 0 && answers_due.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
